FILE: design/sine_frequency_sweep_generator_core_assert.svh
// assertion macros for the sweep generator core
`ifndef SINE_FREQUENCY_SWEEP_GENERATOR_CORE_ASSERT_SVH
`define SINE_FREQUENCY_SWEEP_GENERATOR_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SFSG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SFSG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/sfsg_pkg.sv
`timescale 1ns / 1ps

package sfsg_pkg;

  localparam int STEP_W  = 4;
  localparam int TABLE_W = 6;

  localparam logic [STEP_W-1:0] STEP_HOLD = 4'd0;
  localparam logic [STEP_W-1:0] STEP_MUTE = 4'd1;
  localparam logic [STEP_W-1:0] STEP_LAST = 4'd9;

  localparam logic [7:0] CMP_RESET = 8'hFF;

  typedef struct packed {
    logic [STEP_W-1:0] step_now;
    logic              sweep_done;
    logic              sync_line;
    logic [7:0]        sample_out;
  } sfsg_result_t;

  localparam logic [7:0] ROM64 [64] = '{
    8'h80, 8'h8C, 8'h98, 8'hA4, 8'hB0, 8'hBB, 8'hC6, 8'hD0, 8'hD9, 8'hE2, 8'hE9, 8'hF0,
    8'hF5, 8'hF9, 8'hFC, 8'hFE, 8'hFF, 8'hFE, 8'hFC, 8'hF9, 8'hF5, 8'hF0, 8'hE9, 8'hE2,
    8'hD9, 8'hD0, 8'hC6, 8'hBB, 8'hB0, 8'hA4, 8'h98, 8'h8C, 8'h7F, 8'h73, 8'h67, 8'h5B,
    8'h4F, 8'h44, 8'h39, 8'h2F, 8'h26, 8'h1D, 8'h16, 8'h0F, 8'h0A, 8'h06, 8'h03, 8'h01,
    8'h00, 8'h01, 8'h03, 8'h06, 8'h0A, 8'h0F, 8'h16, 8'h1D, 8'h26, 8'h2F, 8'h39, 8'h44,
    8'h4F, 8'h5B, 8'h67, 8'h73
  };

  localparam logic [7:0] ROM16 [16] = '{
    8'h80, 8'hB1, 8'hDA, 8'hF5, 8'hFF, 8'hF5, 8'hDA, 8'hB1,
    8'h80, 8'h4F, 8'h26, 8'h0B, 8'h00, 8'h0B, 8'h26, 8'h4F
  };

  localparam logic [7:0] ROM8 [8] = '{
    8'h80, 8'hDA, 8'hFF, 8'hDA, 8'h80, 8'h26, 8'h00, 8'h26
  };

  // per step: sample timer compare and sync level
  localparam logic [7:0] STEP_CMP [10] = '{
    8'hFF, 8'hFF, 8'h61, 8'h30, 8'h09, 8'h13, 8'h09, 8'h04, 8'h04, 8'h01
  };

  localparam logic STEP_SYNC [10] = '{
    1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0
  };

endpackage

FILE: design/sfsg_sweep.sv
`timescale 1ns / 1ps

module sfsg_sweep #(
  parameter int SLOW_RATIO = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      tick,
  input  logic [15:0]               step_period,
  output sfsg_pkg::sfsg_result_t    res
);

  localparam int PRE_W = (SLOW_RATIO > 1) ? $clog2(SLOW_RATIO) : 1;
  localparam logic [PRE_W-1:0] PRE_MAX = PRE_W'(SLOW_RATIO - 1);

  logic [PRE_W-1:0]                 prescale_r, prescale_nxt;
  logic [15:0]                      step_count_r, step_count_nxt;
  logic [7:0]                       sample_count_r, sample_count_nxt;
  logic [7:0]                       sample_cmp_r, sample_cmp_nxt;
  logic [sfsg_pkg::STEP_W-1:0]      step_r, step_nxt;
  logic [sfsg_pkg::TABLE_W-1:0]     table_r, table_nxt;
  logic [7:0]                       out_byte_r, out_byte_nxt;
  logic                             sync_r, sync_nxt;
  logic                             done;
  logic                             slow;
  logic                             sample_fire;

  always_comb begin
    prescale_nxt     = prescale_r;
    step_count_nxt   = step_count_r;
    sample_count_nxt = sample_count_r;
    sample_cmp_nxt   = sample_cmp_r;
    step_nxt         = step_r;
    table_nxt        = table_r;
    out_byte_nxt     = out_byte_r;
    sync_nxt         = sync_r;
    done             = 1'b0;
    slow             = 1'b0;
    sample_fire      = 1'b0;
    if (tick) begin
      slow         = (prescale_r == PRE_MAX);
      prescale_nxt = slow ? '0 : prescale_r + 1'b1;

      sample_fire      = (sample_count_r == sample_cmp_r);
      sample_count_nxt = sample_fire ? 8'd0 : sample_count_r + 8'd1;

      // step timer first, sample update sees the new step
      if (slow) begin
        if (step_count_r == step_period) begin
          step_count_nxt = 16'd0;
          table_nxt      = '0;
          if (step_r >= sfsg_pkg::STEP_LAST) begin
            sync_nxt     = 1'b1;
            step_nxt     = sfsg_pkg::STEP_HOLD;
            out_byte_nxt = 8'd0;
            done         = 1'b1;
          end else begin
            step_nxt       = step_r + 1'b1;
            sample_cmp_nxt = sfsg_pkg::STEP_CMP[step_nxt];
            sync_nxt       = sfsg_pkg::STEP_SYNC[step_nxt];
          end
        end else begin
          step_count_nxt = step_count_r + 16'd1;
        end
      end

      if (sample_fire) begin
        if (step_nxt == sfsg_pkg::STEP_MUTE) begin
          out_byte_nxt = 8'd0;
        end else if (step_nxt inside {[4'd2:4'd4]}) begin
          out_byte_nxt = sfsg_pkg::ROM64[table_nxt];
          table_nxt    = table_nxt + 1'b1;
        end else if (step_nxt inside {[4'd5:4'd7]}) begin
          out_byte_nxt = sfsg_pkg::ROM16[table_nxt[3:0]];
          table_nxt    = {2'b00, table_nxt[3:0] + 4'd1};
        end else if (step_nxt inside {[4'd8:4'd9]}) begin
          out_byte_nxt = sfsg_pkg::ROM8[table_nxt[2:0]];
          table_nxt    = {3'b000, table_nxt[2:0] + 3'd1};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r     <= '0;
      step_count_r   <= 16'd0;
      sample_count_r <= 8'd0;
      sample_cmp_r   <= sfsg_pkg::CMP_RESET;
      step_r         <= sfsg_pkg::STEP_HOLD;
      table_r        <= '0;
      out_byte_r     <= 8'd0;
      sync_r         <= 1'b0;
    end else if (adv) begin
      prescale_r     <= prescale_nxt;
      step_count_r   <= step_count_nxt;
      sample_count_r <= sample_count_nxt;
      sample_cmp_r   <= sample_cmp_nxt;
      step_r         <= step_nxt;
      table_r        <= table_nxt;
      out_byte_r     <= out_byte_nxt;
      sync_r         <= sync_nxt;
    end
  end

  assign res.step_now   = step_nxt;
  assign res.sweep_done = done;
  assign res.sync_line  = sync_nxt;
  assign res.sample_out = out_byte_nxt;

endmodule

FILE: design/sine_frequency_sweep_generator_core.sv
`timescale 1ns / 1ps

// Sine frequency sweep generator. Each input transfer is one sample-clock tick
// (tdata bit 0 set) or an idle slot (bit 0 clear); every input transfer gives
// exactly one output transfer carrying the output byte, sync level and step
// after that tick, with tlast high on the tick that completes a sweep. One
// transfer is taken per clock; its result appears on the output in the next
// cycle from a single output register, and a new transfer is taken in the
// same cycle that register is drained, so throughput is one per clock while
// out_tready stays high. step_period (cfg_wdata on cfg_we) sets the step
// length in prescaled counts and should be written while the block is idle.
module sine_frequency_sweep_generator_core #(
  parameter int SLOW_RATIO = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // tick, zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // sample_out, sync_line, step_now, zero fill
  output logic        out_tlast   // sweep_done
);

  logic [15:0]            period_r;
  logic                   out_valid_r;
  sfsg_pkg::sfsg_result_t out_data_r;
  sfsg_pkg::sfsg_result_t res;
  logic                   in_xfer;

  assign in_tready     = !out_valid_r || out_tready;
  assign in_xfer       = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= 16'h4FFF;
    end else if (cfg_we) begin
      period_r <= cfg_wdata;
    end
  end

  sfsg_sweep #(
    .SLOW_RATIO (SLOW_RATIO)
  ) u_sweep (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (in_xfer),
    .tick        (in_tdata[0]),
    .step_period (period_r),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_data_r.step_now, out_data_r.sync_line,
                       out_data_r.sample_out};
  assign out_tlast  = out_data_r.sweep_done;

`include "sine_frequency_sweep_generator_core_assert.svh"

  `SFSG_ASSERT_NEXT(a_xfer_gives_result, in_xfer, out_tvalid,
    "accepted transfer did not produce a result")
  `SFSG_ASSERT_SAME(a_step_range, out_tvalid, out_data_r.step_now <= sfsg_pkg::STEP_LAST,
    "step out of range")
  `SFSG_ASSERT_SAME(a_done_state, out_tvalid && out_tlast,
    out_data_r.step_now == sfsg_pkg::STEP_HOLD && out_data_r.sync_line &&
    out_data_r.sample_out == 8'd0,
    "sweep end did not return to step zero")
  `SFSG_ASSERT_SAME(a_idle_no_done, in_xfer && !in_tdata[0], !res.sweep_done,
    "sweep completed without a tick")

endmodule
